### rtl/core/rfp_pkg.sv
// Shared types, widths and constants of the detector level converter.
// Used by rfp_poly, rfp_lin and rf_power_poly_dbm_to_watt_core; depends on nothing.
package rfp_pkg;

   localparam int RFP_ADC_BITS = 12;
   localparam int DATA_W       = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int DB_ONE       = 65536;

   localparam int X_W   = 17;
   localparam int P1_W  = 49;
   localparam int T1_W  = 34;
   localparam int P2_W  = 51;
   localparam int T2_W  = 36;
   localparam int P3_W  = 53;
   localparam int LVL_W = 48;
   localparam int A_W   = 25;
   localparam int PE_W  = 57;
   localparam int E_W   = 24;
   localparam int XS_W  = 27;
   localparam int Y_W   = 28;
   localparam int T_W   = 31;
   localparam int M_W   = 32;

   localparam logic signed [DATA_W-1:0] RST_COEF0  = 32'sd1838116;
   localparam logic signed [DATA_W-1:0] RST_COEF1  = -32'sd575868;
   localparam logic signed [DATA_W-1:0] RST_COEF2  = 32'sd6124916;
   localparam logic signed [DATA_W-1:0] RST_COEF3  = -32'sd73202080;
   localparam logic signed [DATA_W-1:0] RST_OFFSET = 32'sd0;

   localparam logic signed [LVL_W-1:0] LVL_M60 = LVL_W'(-60 * DB_ONE);
   localparam logic signed [LVL_W-1:0] LVL_M30 = LVL_W'(-30 * DB_ONE);
   localparam logic signed [LVL_W-1:0] LVL_P30 = LVL_W'(30 * DB_ONE);

   localparam logic signed [7:0] SH_PW = 8'sd90;
   localparam logic signed [7:0] SH_NW = 8'sd60;
   localparam logic signed [7:0] SH_UW = 8'sd30;
   localparam logic signed [7:0] SH_MW = 8'sd0;
   localparam logic signed [7:0] SH_W  = -8'sd30;
   localparam logic signed [7:0] N_TOP = 8'sd14;

   localparam logic signed [A_W-1:0] A_MAX = A_W'(200 * DB_ONE);
   localparam logic signed [A_W-1:0] A_MIN = A_W'(-200 * DB_ONE);
   localparam logic signed [E_W-1:0] E_SAT  = E_W'(15 * DB_ONE);
   localparam logic signed [E_W-1:0] E_ZERO = E_W'(-17 * DB_ONE);

   localparam logic signed [31:0] LOG2_10_DIV10 = 32'sd1426757253;
   localparam logic [29:0]        LN2_Q30       = 30'd744261118;
   localparam logic [T_W-1:0]     ONE_Q30       = 31'h4000_0000;
   localparam logic [31:0]        RECIP5        = 32'hCCCC_CCCD;
   localparam logic [31:0]        RECIP3        = 32'hAAAA_AAAB;
   localparam logic [DATA_W-1:0]  SAT_POS       = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]  SAT_NEG       = 32'h8000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] c0;
      logic signed [DATA_W-1:0] c1;
      logic signed [DATA_W-1:0] c2;
      logic signed [DATA_W-1:0] c3;
      logic signed [DATA_W-1:0] offset;
   } coef_type;

   typedef struct packed {
      logic signed [LVL_W-1:0] level;
      logic                    dbm_mode;
   } lvl_type;

   typedef enum logic [2:0] {
      UNIT_DBM = 3'd0,
      UNIT_W   = 3'd1,
      UNIT_MW  = 3'd2,
      UNIT_UW  = 3'd3,
      UNIT_NW  = 3'd4,
      UNIT_PW  = 3'd5
   } unit_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF0  = 3'd0,
      CSR_COEF1  = 3'd1,
      CSR_COEF2  = 3'd2,
      CSR_COEF3  = 3'd3,
      CSR_OFFSET = 3'd4
   } csr_index_type;

   // Powers of two in eighth-octave steps, Q1.30.
   function automatic logic [T_W-1:0] pow2_eighth(input logic [2:0] idx);
      logic [T_W-1:0] val;
      unique case (idx)
         3'd0: val = 31'd1073741824;
         3'd1: val = 31'd1170923762;
         3'd2: val = 31'd1276901417;
         3'd3: val = 31'd1392470869;
         3'd4: val = 31'd1518500250;
         3'd5: val = 31'd1655936265;
         3'd6: val = 31'd1805811301;
         3'd7: val = 31'd1969251188;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/rfp_poly.sv
// Six-stage pipeline that evaluates the cubic calibration polynomial in Horner form.
// Depends on rfp_pkg for widths and the coefficient and level types.
module rfp_poly #(
   parameter int ADC_BITS = rfp_pkg::RFP_ADC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  rfp_pkg::coef_type  coef,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [ADC_BITS-1:0] in_code,
   input  logic               in_dbm_mode,
   output logic               out_valid,
   input  logic               out_ready,
   output rfp_pkg::lvl_type   out_lvl
);
   import rfp_pkg::*;

   localparam int NS = 6;

   logic [NS-1:0] vld_ff, vld_in, adv;

   logic signed [X_W-1:0]   x_in;
   logic signed [X_W-1:0]   x_ff [0:NS-3];
   logic                    m_ff [0:NS-1];
   logic signed [P1_W-1:0]  p1_ff, p1_in;
   logic signed [T1_W-1:0]  t1_ff, t1_in;
   logic signed [P2_W-1:0]  p2_ff, p2_in;
   logic signed [T2_W-1:0]  t2_ff, t2_in;
   logic signed [P3_W-1:0]  p3_ff, p3_in;
   logic signed [LVL_W-1:0] lvl_ff, lvl_in;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         adv[i] = out_ready || ((vld_ff | NS'((1 << i) - 1)) != {NS{1'b1}});
      end
   end

   assign vld_in = {vld_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (adv & vld_in) | (~adv & vld_ff);
      end
   end

   assign x_in  = X_W'(in_code);
   assign p1_in = P1_W'(coef.c3) * P1_W'(x_in);
   assign t1_in = T1_W'(coef.c2) + T1_W'(p1_ff >>> 16);
   assign p2_in = P2_W'(t1_ff) * P2_W'(x_ff[1]);
   assign t2_in = T2_W'(coef.c1) + T2_W'(p2_ff >>> 16);
   assign p3_in = P3_W'(t2_ff) * P3_W'(x_ff[3]);
   assign lvl_in = LVL_W'(coef.c0) + LVL_W'(p3_ff >>> 8) - LVL_W'(coef.offset);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0] <= x_in;
         m_ff[0] <= in_dbm_mode;
         p1_ff   <= p1_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            m_ff[k] <= m_ff[k-1];
         end
      end
      for (int k = 1; k < NS-2; k++) begin
         if (adv[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
      if (adv[1]) begin
         t1_ff <= t1_in;
      end
      if (adv[2]) begin
         p2_ff <= p2_in;
      end
      if (adv[3]) begin
         t2_ff <= t2_in;
      end
      if (adv[4]) begin
         p3_ff <= p3_in;
      end
      if (adv[5]) begin
         lvl_ff <= lvl_in;
      end
   end

   assign in_ready          = adv[0];
   assign out_valid         = vld_ff[NS-1];
   assign out_lvl.level     = lvl_ff;
   assign out_lvl.dbm_mode  = m_ff[NS-1];

endmodule

### rtl/core/rfp_lin.sv
// Twelve-stage pipeline from a dBm level to a unit code and a saturated Q16.16 value.
// Depends on rfp_pkg for widths, thresholds, the exp2 table and the unit codes.
module rfp_lin (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rfp_pkg::lvl_type          in_lvl,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [rfp_pkg::DATA_W-1:0] out_value,
   output rfp_pkg::unit_type         out_unit
);
   import rfp_pkg::*;

   localparam int NS = 12;

   typedef struct packed {
      logic              dbm_mode;
      unit_type          unit;
      logic [DATA_W-1:0] dbm_val;
   } side_type;

   typedef struct packed {
      logic signed [7:0] n;
      logic [2:0]        idx;
      logic              sat;
      logic              zero;
   } exps_type;

   logic [NS-1:0] vld_ff, vld_in, adv;

   side_type                side_ff [0:NS-2];
   side_type                side_in;
   exps_type                ex_ff [3:NS-2];
   exps_type                ex_in;
   logic [XS_W-1:0]         xs_ff [3:8];
   logic [XS_W-1:0]         xs_in;
   logic signed [LVL_W-1:0] lvl_ff;
   logic signed [7:0]       sh_ff, sh_in;
   logic signed [LVL_W-1:0] a_sum;
   logic signed [A_W-1:0]   a_ff, a_in;
   logic signed [PE_W-1:0]  prod_ff, prod_in;
   logic signed [E_W-1:0]   e_val;
   logic [T_W-1:0]          t5_ff, t5_in, t4_ff, t4_in, t3_ff, t3_in;
   logic [T_W-1:0]          t2_ff, t2_in, t1_ff, t1_in;
   logic [Y_W-1:0]          y3_ff, y3_in;
   logic [M_W-1:0]          m_ff, m_in, m_sh;
   logic signed [7:0]       sh_amt;
   logic [DATA_W-1:0]       val_ff, val_in, lin_val;
   unit_type                unit_ff, unit_in;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         adv[i] = out_ready || ((vld_ff | NS'((1 << i) - 1)) != {NS{1'b1}});
      end
   end

   assign vld_in = {vld_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (adv & vld_in) | (~adv & vld_ff);
      end
   end

   always_comb begin
      side_in.dbm_mode = in_lvl.dbm_mode;
      priority if (in_lvl.level < LVL_M60) begin
         side_in.unit = UNIT_PW;
         sh_in        = SH_PW;
      end else if (in_lvl.level < LVL_M30) begin
         side_in.unit = UNIT_NW;
         sh_in        = SH_NW;
      end else if (in_lvl.level[LVL_W-1]) begin
         side_in.unit = UNIT_UW;
         sh_in        = SH_UW;
      end else if (in_lvl.level < LVL_P30) begin
         side_in.unit = UNIT_MW;
         sh_in        = SH_MW;
      end else begin
         side_in.unit = UNIT_W;
         sh_in        = SH_W;
      end
      if ((in_lvl.level[LVL_W-1:DATA_W-1] == '0) || (in_lvl.level[LVL_W-1:DATA_W-1] == '1)) begin
         side_in.dbm_val = in_lvl.level[DATA_W-1:0];
      end else begin
         side_in.dbm_val = in_lvl.level[LVL_W-1] ? SAT_NEG : SAT_POS;
      end
   end

   always_comb begin
      a_sum = lvl_ff + (LVL_W'(sh_ff) <<< 16);
      priority if (a_sum > LVL_W'(A_MAX)) begin
         a_in = A_MAX;
      end else if (a_sum < LVL_W'(A_MIN)) begin
         a_in = A_MIN;
      end else begin
         a_in = A_W'(a_sum);
      end
   end

   assign prod_in = PE_W'(a_ff) * PE_W'(LOG2_10_DIV10);

   assign e_val      = E_W'(prod_ff >>> 32);
   assign ex_in.n    = e_val[E_W-1:16];
   assign ex_in.idx  = e_val[15:13];
   assign ex_in.sat  = (e_val >= E_SAT);
   assign ex_in.zero = (e_val < E_ZERO);
   assign xs_in      = XS_W'((43'(e_val[12:0]) * 43'(LN2_Q30)) >> 16);

   assign t5_in = ONE_Q30 + T_W'((59'(xs_ff[3]) * 59'(RECIP5)) >> 34);
   assign t4_in = ONE_Q30 + T_W'((58'(xs_ff[4]) * 58'(t5_ff)) >> 32);
   assign y3_in = Y_W'((58'(xs_ff[5]) * 58'(t4_ff)) >> 30);
   assign t3_in = ONE_Q30 + T_W'((60'(y3_ff) * 60'(RECIP3)) >> 33);
   assign t2_in = ONE_Q30 + T_W'((58'(xs_ff[7]) * 58'(t3_ff)) >> 31);
   assign t1_in = ONE_Q30 + T_W'((58'(xs_ff[8]) * 58'(t2_ff)) >> 30);
   assign m_in  = M_W'((62'(pow2_eighth(ex_ff[9].idx)) * 62'(t1_ff)) >> 30);

   always_comb begin
      sh_amt = N_TOP - ex_ff[10].n;
      m_sh   = m_ff >> sh_amt[4:0];
      priority if (ex_ff[10].sat) begin
         lin_val = SAT_POS;
      end else if (ex_ff[10].zero) begin
         lin_val = '0;
      end else if (m_sh > SAT_POS) begin
         lin_val = SAT_POS;
      end else begin
         lin_val = m_sh;
      end
      if (side_ff[10].dbm_mode) begin
         val_in  = side_ff[10].dbm_val;
         unit_in = UNIT_DBM;
      end else begin
         val_in  = lin_val;
         unit_in = side_ff[10].unit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         side_ff[0] <= side_in;
         lvl_ff     <= in_lvl.level;
         sh_ff      <= sh_in;
      end
      for (int k = 1; k < NS-1; k++) begin
         if (adv[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (adv[1]) begin
         a_ff <= a_in;
      end
      if (adv[2]) begin
         prod_ff <= prod_in;
      end
      if (adv[3]) begin
         ex_ff[3] <= ex_in;
         xs_ff[3] <= xs_in;
      end
      for (int k = 4; k < NS-1; k++) begin
         if (adv[k]) begin
            ex_ff[k] <= ex_ff[k-1];
         end
      end
      for (int k = 4; k <= 8; k++) begin
         if (adv[k]) begin
            xs_ff[k] <= xs_ff[k-1];
         end
      end
      if (adv[4]) begin
         t5_ff <= t5_in;
      end
      if (adv[5]) begin
         t4_ff <= t4_in;
      end
      if (adv[6]) begin
         y3_ff <= y3_in;
      end
      if (adv[7]) begin
         t3_ff <= t3_in;
      end
      if (adv[8]) begin
         t2_ff <= t2_in;
      end
      if (adv[9]) begin
         t1_ff <= t1_in;
      end
      if (adv[10]) begin
         m_ff <= m_in;
      end
      if (adv[11]) begin
         val_ff  <= val_in;
         unit_ff <= unit_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NS-1];
   assign out_value = val_ff;
   assign out_unit  = unit_ff;

endmodule

### rtl/core/rf_power_poly_dbm_to_watt_core.sv
// Top level of the detector level converter: calibration registers and the two pipelines.
// Depends on rfp_pkg, rfp_poly and rfp_lin.
//
// Usage: a request carries one detector code (req_adc_code) and a mode bit
// (req_dbm_mode) and is taken when req_valid and req_ready are both high.
// Each request gives exactly one response on the rsp_ channel: a Q16.16 value
// and a unit code. In dBm mode the value is the calibrated level in dBm;
// otherwise it is a linear power in W, mW, uW, nW or pW, at least 1 except in pW
// and below 1000 except in W. A request passes through 18 register stages, and
// while rsp_ready stays high one request can be taken every cycle and results
// come out one per cycle. When the receiver holds rsp_ready low, the response
// holds and the stages behind it keep filling; req_ready falls only once every
// stage holds a request. Each multiplier in both pipelines is used once per
// request. The five calibration registers are written through csr_we,
// csr_index and csr_wdata, one register per cycle; the user must write them
// only while no request is in flight, as the block does not enforce this.
// Reset empties the pipeline and loads the default calibration.
module rf_power_poly_dbm_to_watt_core #(
   parameter int ADC_BITS = rfp_pkg::RFP_ADC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ADC_BITS-1:0]                 req_adc_code,
   input  logic                                req_dbm_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rfp_pkg::DATA_W-1:0]   rsp_level_value,
   output logic [2:0]                          rsp_unit_code,
   input  logic                                csr_we,
   input  logic [rfp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rfp_pkg::DATA_W-1:0]          csr_wdata
);
   import rfp_pkg::*;

   coef_type coef_ff, coef_in;
   lvl_type  lvl;
   logic     lvl_valid, lvl_ready;
   unit_type unit;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COEF0:  coef_in.c0     = csr_wdata;
            CSR_COEF1:  coef_in.c1     = csr_wdata;
            CSR_COEF2:  coef_in.c2     = csr_wdata;
            CSR_COEF3:  coef_in.c3     = csr_wdata;
            CSR_OFFSET: coef_in.offset = csr_wdata;
            default:    coef_in        = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.c0     <= RST_COEF0;
         coef_ff.c1     <= RST_COEF1;
         coef_ff.c2     <= RST_COEF2;
         coef_ff.c3     <= RST_COEF3;
         coef_ff.offset <= RST_OFFSET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   rfp_poly #(
      .ADC_BITS(ADC_BITS)
   ) u_poly (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_code    (req_adc_code),
      .in_dbm_mode(req_dbm_mode),
      .out_valid  (lvl_valid),
      .out_ready  (lvl_ready),
      .out_lvl    (lvl)
   );

   rfp_lin u_lin (
      .clock    (clock),
      .reset    (reset),
      .in_valid (lvl_valid),
      .in_ready (lvl_ready),
      .in_lvl   (lvl),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_value(rsp_level_value),
      .out_unit (unit)
   );

   assign rsp_unit_code = unit;

`ifndef SYNTHESIS
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused although the output side can move");

   a_linear_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unit_code != UNIT_DBM) |-> !rsp_level_value[DATA_W-1])
      else $error("negative linear power");

   a_decade_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unit_code != UNIT_DBM && rsp_unit_code != UNIT_PW)
      |-> (rsp_level_value >= 32'sd65536))
      else $error("linear power below one in a decade unit");
`endif

endmodule
